// File: hdl/otmc_pkg.sv
// Shared types and constants for the object table with motion and collision.
// No dependencies.
package otmc_pkg;

    localparam logic [3:0] OP_CLEAR     = 4'd0;
    localparam logic [3:0] OP_SPAWN     = 4'd1;
    localparam logic [3:0] OP_DESTROY   = 4'd2;
    localparam logic [3:0] OP_READ      = 4'd3;
    localparam logic [3:0] OP_SETPOS    = 4'd4;
    localparam logic [3:0] OP_SETVEL    = 4'd5;
    localparam logic [3:0] OP_SETSIZE   = 4'd6;
    localparam logic [3:0] OP_SETTIMER  = 4'd7;
    localparam logic [3:0] OP_TICK      = 4'd8;
    localparam logic [3:0] OP_MOVE      = 4'd9;
    localparam logic [3:0] OP_FIND      = 4'd10;
    localparam logic [3:0] OP_COUNTKIND = 4'd11;
    localparam logic [3:0] OP_COUNTALL  = 4'd12;
    localparam logic [3:0] OP_PAIR      = 4'd13;
    localparam logic [3:0] OP_COLLKIND  = 4'd14;
    localparam logic [3:0] OP_CONTAINS  = 4'd15;

    localparam logic [7:0] SIZE_RESET = 8'd8;

    // One table entry without its active mark.
    typedef struct packed {
        logic [7:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [7:0]  box_w;
        logic [7:0]  box_h;
        logic [15:0] countdown;
    } entry_t;

    // Box edges of one entry.
    typedef struct packed {
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
    } box_t;

    function automatic box_t make_box(input entry_t e);
        box_t b;
        b.x0 = e.pos_x;
        b.y0 = e.pos_y;
        b.x1 = e.pos_x + {e.box_w, 8'h00};
        b.y1 = e.pos_y + {e.box_h, 8'h00};
        return b;
    endfunction

    function automatic logic overlap(input box_t a, input box_t b);
        return ($signed(a.x0) < $signed(b.x1)) && ($signed(a.x1) > $signed(b.x0))
            && ($signed(a.y0) < $signed(b.y1)) && ($signed(a.y1) > $signed(b.y0));
    endfunction

endpackage

// File: hdl/otmc_table.sv
// Entry memory with one synchronous read port and one write port.
// Depends on otmc_pkg.
module otmc_table
    import otmc_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int AW = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/object_table_motion_collision.sv
// Top level of the object table with motion and collision.
// Depends on otmc_pkg and otmc_table.
//
// One word is taken while busy is low and start is high; its result shows for one cycle
// with done high and cannot be held off. Entries live in a memory with synchronous reads;
// active marks are flip-flops. Spawn and single-entry operations make one read and then
// finish, a pair test reads both slots in turn, and a word with an out of range slot goes
// to its result without a read. Clear sweeps the memory, one entry a cycle, and a scan
// (tick, move, find, count) reads one entry a cycle; collide with kind reads its own slot
// before it scans. At reset the block is busy while the memory is swept to its reset values.
module object_table_motion_collision
    import otmc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         operation,
    input  logic [3:0]         slot,
    input  logic [3:0]         other_slot,
    input  logic [7:0]         kind,
    input  logic signed [15:0] value_a,
    input  logic signed [15:0] value_b,
    output logic               done,
    output logic               ok,
    output logic [3:0]         found_slot,
    output logic [4:0]         tally,
    output logic               entry_active,
    output logic [7:0]         entry_kind,
    output logic signed [15:0] entry_x,
    output logic signed [15:0] entry_y
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;  // data of the first operand back; a pair test issues the second read
    localparam logic [2:0] S_RDB   = 3'd3;  // data of the second operand back
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [ENTRIES-1:0] act_reg, act_next;
    logic [3:0]  op_reg;
    logic [AW-1:0] s_reg, t_reg;
    logic [7:0]  kind_reg;
    logic [15:0] va_reg, vb_reg;
    logic        sbad_reg;
    logic [AW-1:0] idx_reg, idx_next;   // address of the read in flight
    logic        last_reg, last_next;
    logic        rv_reg, rv_next;       // a scan read is in flight
    entry_t      a_reg;                 // first operand copy
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        hit_reg, hit_next;
    logic [AW-1:0] fnd_reg, fnd_next;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    entry_t      wdata, rdata, fresh;
    box_t        box_a, box_r;
    logic        r_act;

    otmc_table #(.ENTRIES(ENTRIES), .AW(AW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        fresh = '0;
        fresh.box_w = SIZE_RESET;
        fresh.box_h = SIZE_RESET;
    end

    assign busy  = (state_reg != S_IDLE);
    assign box_a = make_box(a_reg);
    assign box_r = make_box(rdata);
    assign r_act = act_reg[idx_reg];

    // Pick the slot operands; out of range slots are flagged, not used.
    logic sbad_in;
    always_comb
    begin
        sbad_in = (32'(slot) >= ENTRIES);
        if (operation == OP_PAIR && 32'(other_slot) >= ENTRIES)
        begin
            sbad_in = 1'b1;
        end
    end

    logic [AW-1:0] free_idx;
    logic          free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_idx = AW'(i);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        rv_next    = 1'b0;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        fnd_next   = fnd_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rdata;
        raddr      = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    hit_next = 1'b0;
                    fnd_next = '0;
                    cnt_next = '0;
                    idx_next = '0;
                    last_next = (ENTRIES == 1);
                    if (operation == OP_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                    else if (operation == OP_SPAWN || operation == OP_TICK
                             || operation == OP_MOVE || operation == OP_FIND
                             || operation == OP_COUNTKIND || operation == OP_COUNTALL)
                    begin
                        state_next = S_SCAN;
                        rv_next = 1'b1;
                        raddr = '0;
                    end
                    else if (sbad_in)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RDA;
                        raddr = AW'(slot);
                    end
                end
            end
            S_CLR:
            begin
                we = 1'b1;
                wdata = fresh;
                act_next = '0;
                hit_next = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDA:
            begin
                // rdata holds entry s; do single-entry work here.
                waddr = s_reg;
                hit_next = 1'b1;
                idx_next = s_reg;
                unique case (op_reg)
                    OP_DESTROY:
                    begin
                        act_next[s_reg] = 1'b0;
                        we = 1'b1;
                        wdata.kind = '0;
                        state_next = S_DONE;
                    end
                    OP_SETPOS:
                    begin
                        we = 1'b1;
                        wdata.pos_x = va_reg;
                        wdata.pos_y = vb_reg;
                        state_next = S_DONE;
                    end
                    OP_SETVEL:
                    begin
                        we = 1'b1;
                        wdata.vel_x = va_reg;
                        wdata.vel_y = vb_reg;
                        state_next = S_DONE;
                    end
                    OP_SETSIZE:
                    begin
                        we = 1'b1;
                        wdata.box_w = va_reg[7:0];
                        wdata.box_h = vb_reg[7:0];
                        state_next = S_DONE;
                    end
                    OP_SETTIMER:
                    begin
                        we = 1'b1;
                        wdata.countdown = va_reg;
                        state_next = S_DONE;
                    end
                    OP_CONTAINS:
                    begin
                        hit_next = act_reg[s_reg]
                            && $signed(va_reg) >= $signed(box_r.x0)
                            && $signed(va_reg) < $signed(box_r.x1)
                            && $signed(vb_reg) >= $signed(box_r.y0)
                            && $signed(vb_reg) < $signed(box_r.y1);
                        state_next = S_DONE;
                    end
                    OP_PAIR:
                    begin
                        raddr = t_reg;
                        state_next = S_RDB;
                    end
                    OP_COLLKIND:
                    begin
                        hit_next = 1'b0;
                        if (act_reg[s_reg])
                        begin
                            raddr = '0;
                            idx_next = '0;
                            last_next = (ENTRIES == 1);
                            rv_next = 1'b1;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;  // read
                    end
                endcase
            end
            S_RDB:
            begin
                hit_next = act_reg[s_reg] && act_reg[t_reg] && overlap(box_a, box_r);
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // rdata holds entry idx_reg.
                if (rv_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr = idx_reg + 1'b1;
                    last_next = ((idx_reg + 1'b1) == LAST);
                    rv_next = !last_reg;
                    if (last_reg)
                    begin
                        state_next = S_DONE;
                    end
                    case (op_reg)
                        OP_SPAWN:
                        begin
                            state_next = S_DONE;
                            rv_next = 1'b0;
                            if (free_any)
                            begin
                                we = 1'b1;
                                waddr = free_idx;
                                wdata = fresh;
                                wdata.kind = kind_reg;
                                wdata.pos_x = va_reg;
                                wdata.pos_y = vb_reg;
                                act_next[free_idx] = 1'b1;
                                hit_next = 1'b1;
                                fnd_next = free_idx;
                            end
                        end
                        OP_TICK, OP_MOVE:
                        begin
                            hit_next = 1'b1;
                            if (r_act)
                            begin
                                we = 1'b1;
                                wdata.pos_x = rdata.pos_x + rdata.vel_x;
                                wdata.pos_y = rdata.pos_y + rdata.vel_y;
                                if (op_reg == OP_TICK && rdata.countdown != '0)
                                begin
                                    wdata.countdown = rdata.countdown - 1'b1;
                                end
                            end
                        end
                        OP_FIND:
                        begin
                            if (r_act && rdata.kind == kind_reg && !hit_reg)
                            begin
                                hit_next = 1'b1;
                                fnd_next = idx_reg;
                            end
                        end
                        OP_COUNTKIND, OP_COUNTALL:
                        begin
                            hit_next = 1'b1;
                            if (r_act && (op_reg == OP_COUNTALL || rdata.kind == kind_reg))
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!hit_reg && r_act && idx_reg != s_reg
                                && rdata.kind == kind_reg && overlap(box_a, box_r))
                            begin
                                hit_next = 1'b1;
                                fnd_next = idx_reg;
                            end
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            act_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            cnt_reg   <= '0;
            fnd_reg   <= '0;
            op_reg    <= OP_CLEAR;
            sbad_reg  <= 1'b1;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            rv_reg    <= rv_next;
            hit_reg   <= hit_next;
            cnt_reg   <= cnt_next;
            fnd_reg   <= fnd_next;
            if (state_reg == S_IDLE && start)
            begin
                op_reg   <= operation;
                sbad_reg <= sbad_in && operation != OP_CLEAR && operation != OP_SPAWN
                    && operation != OP_TICK && operation != OP_MOVE && operation != OP_FIND
                    && operation != OP_COUNTKIND && operation != OP_COUNTALL;
            end
            // The power-up sweep ends without a result word.
            done <= (state_reg == S_DONE) && !(op_reg == OP_CLEAR && sbad_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            s_reg    <= AW'(slot);
            t_reg    <= AW'(other_slot);
            kind_reg <= kind;
            va_reg   <= value_a;
            vb_reg   <= value_b;
        end
        if (state_reg == S_RDA)
        begin
            a_reg <= rdata;
        end
        if (state_reg == S_DONE)
        begin
            ok           <= hit_reg && !sbad_reg;
            found_slot   <= (hit_reg && !sbad_reg) ? 4'(fnd_reg) : 4'd0;
            tally        <= (op_reg == OP_COUNTKIND || op_reg == OP_COUNTALL)
                            ? 5'(cnt_reg) : 5'd0;
            entry_active <= 1'b0;
            entry_kind   <= '0;
            entry_x      <= '0;
            entry_y      <= '0;
            if (op_reg == OP_READ && !sbad_reg)
            begin
                entry_active <= act_reg[s_reg];
                entry_kind   <= a_reg.kind;
                entry_x      <= a_reg.pos_x;
                entry_y      <= a_reg.pos_y;
            end
        end
    end

endmodule
